// ----- rtl/core/lamport_direction_gate_arbiter_top_macros.svh -----
// assertion macros for the lamport direction gate arbiter checker
// expects clk and rst in the scope where a macro is used
`ifndef LAMPORT_DIRECTION_GATE_ARBITER_TOP_MACROS_SVH
`define LAMPORT_DIRECTION_GATE_ARBITER_TOP_MACROS_SVH

// checked outside reset
`define LGDA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define LGDA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/core/lgda_pkg.sv -----
// shared types, codes and helpers for the lamport direction gate arbiter
// no dependencies
package lgda_pkg;

  localparam int NODES_DEF = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 5;

  localparam logic [2:0] OP_START = 3'd0;
  localparam logic [2:0] OP_REQUEST = 3'd1;
  localparam logic [2:0] OP_ACK = 3'd2;
  localparam logic [2:0] OP_RELEASE = 3'd3;
  localparam logic [2:0] OP_ENTER = 3'd4;
  localparam logic [2:0] OP_LEAVE = 3'd5;

  localparam logic [2:0] KIND_NONE = 3'd0;
  localparam logic [2:0] KIND_REQUEST = 3'd1;
  localparam logic [2:0] KIND_ACK = 3'd2;
  localparam logic [2:0] KIND_ENTER = 3'd3;
  localparam logic [2:0] KIND_RELEASE = 3'd4;

  localparam logic [1:0] DIR_NONE = 2'd0;

  localparam logic [CFG_IDX_W-1:0] REG_NODE_RANK = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NODE_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OWN_DIRECTION = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GATE_CAPACITY = 2'd3;

  localparam logic [4:0] ACK_MAX = 5'd31;

  typedef struct packed {
    logic [2:0]  operation;
    logic [31:0] msg_timestamp;
    logic [3:0]  msg_rank;
    logic [1:0]  msg_direction;
  } item_t;

  typedef struct packed {
    logic [2:0]  send_kind;
    logic [31:0] send_timestamp;
    logic [3:0]  send_dest;
    logic [1:0]  gate_direction;
    logic        granted;
    logic        last_result;
  } res_t;

  typedef struct packed {
    logic [31:0] ts;
    logic [3:0]  rank;
    logic [1:0]  dir;
  } entry_t;

  // command broadcast to every queue cell
  typedef struct packed {
    logic       ins;
    logic       rem;
    entry_t     ent;
    logic [3:0] key;
  } qcmd_t;

  // saturating lamport tick
  function automatic logic [31:0] tick(input logic [31:0] v);
    tick = (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

endpackage

// ----- rtl/core/lamport_direction_gate_arbiter_top.sv -----
// One node of a Lamport-clock mutual exclusion group with a two-direction gate.
// Words are taken one at a time: in_stall is low only while the node is idle.
// A start or an ignored word goes from exec straight to loading its first result word;
// a leave that ends the node and the peer messages first pass the scan, which walks the
// queue cell chain and the inside flags one position per cycle, and the decide state.
// Each word then yields one or two result words, paced by out_stall.
// depends on lgda_pkg and lgda_queue
module lamport_direction_gate_arbiter_top #(
  parameter int NODES = lgda_pkg::NODES_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  lgda_pkg::item_t                   in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output lgda_pkg::res_t                    out_data,
  input  logic                              cfg_wr_en,
  input  logic [lgda_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lgda_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int IDX_W = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int CNT_W = $clog2(NODES + 1);
  localparam int CMP_W = (CNT_W > 5) ? CNT_W : 5;

  typedef enum logic [2:0] {
    S_IDLE, S_EXEC, S_TICK2, S_SCAN, S_DECIDE, S_LOAD, S_EMIT
  } state_t;

  state_t            state;
  lgda_pkg::item_t   it;
  logic [3:0]        node_rank;
  logic [4:0]        node_count;
  logic [1:0]        own_dir;
  logic [4:0]        gate_cap;
  logic [31:0]       clock_value;
  logic [NODES-1:0]  flags;
  logic [4:0]        ack_total;
  logic [1:0]        cur_dir;
  logic              inside_self;
  logic              finished;
  logic [IDX_W-1:0]  scan_idx;
  logic [CNT_W-1:0]  total;
  logic [CNT_W-1:0]  seen_a;
  logic [CNT_W-1:0]  seen_b;
  logic              done_a;
  logic              done_b;
  logic              front_a;
  logic              front_b;
  logic              first_v;
  logic [2:0]        first_kind;
  logic [31:0]       first_ts;
  logic [3:0]        first_dest;
  logic              grant_v;
  logic              more;

  lgda_pkg::qcmd_t   cmd;
  lgda_pkg::entry_t  ents [NODES];
  logic [CNT_W-1:0]  q_count;
  logic              q_hit;

  logic [31:0]       msg_max;
  logic              start_ok;
  lgda_pkg::entry_t  scan_ent;
  logic              scan_occ;
  logic [1:0]        head_dir;
  logic              revisit;
  logic [1:0]        dir_new;
  logic              front;
  logic [4:0]        need;
  logic              grant;
  lgda_pkg::res_t    enter_res;
  lgda_pkg::res_t    none_res;

  lgda_queue #(.NODES(NODES), .CNT_W(CNT_W)) u_queue (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .ents    (ents),
    .count   (q_count),
    .any_hit (q_hit)
  );

  assign in_stall = (state != S_IDLE);
  assign msg_max = (it.msg_timestamp > clock_value) ? it.msg_timestamp : clock_value;
  assign start_ok = !inside_self && !q_hit;
  assign scan_ent = ents[scan_idx];
  assign scan_occ = CNT_W'(scan_idx) < q_count;
  assign head_dir = ents[0].dir;

  always_comb begin
    cmd = '0;
    if ((it.operation == lgda_pkg::OP_START) || (it.operation == lgda_pkg::OP_LEAVE)) begin
      cmd.key = node_rank;
    end else begin
      cmd.key = it.msg_rank;
    end
    if (it.operation == lgda_pkg::OP_START) begin
      cmd.ent.ts = lgda_pkg::tick(clock_value);
      cmd.ent.rank = node_rank;
      cmd.ent.dir = own_dir;
    end else begin
      cmd.ent.ts = it.msg_timestamp;
      cmd.ent.rank = it.msg_rank;
      cmd.ent.dir = it.msg_direction;
    end
    if ((state == S_EXEC) && !finished) begin
      cmd.ins = (((it.operation == lgda_pkg::OP_START) && start_ok) ||
                 (it.operation == lgda_pkg::OP_REQUEST)) && (q_count < CNT_W'(NODES));
      cmd.rem = (it.operation == lgda_pkg::OP_RELEASE) ||
                ((it.operation == lgda_pkg::OP_LEAVE) && inside_self);
    end
  end

  // direction update and grant check after the scan
  always_comb begin
    revisit = (it.operation != lgda_pkg::OP_ENTER);
    if (!revisit) begin
      dir_new = cur_dir;
    end else if (q_count == '0) begin
      dir_new = lgda_pkg::DIR_NONE;
    end else if ((cur_dir == lgda_pkg::DIR_NONE) ||
                 ((head_dir != cur_dir) && (total == '0))) begin
      dir_new = head_dir;
    end else begin
      dir_new = cur_dir;
    end
    front = (dir_new == cur_dir) ? front_a : front_b;
    need = (node_count == 5'd0) ? 5'd0 : node_count - 5'd1;
    grant = (it.operation != lgda_pkg::OP_LEAVE) && !inside_self &&
            (dir_new != lgda_pkg::DIR_NONE) && (own_dir == dir_new) && front &&
            (CMP_W'(total) < CMP_W'(gate_cap)) && (ack_total >= need);
  end

  always_comb begin
    enter_res = '0;
    enter_res.send_kind = lgda_pkg::KIND_ENTER;
    enter_res.send_timestamp = clock_value;
    enter_res.gate_direction = cur_dir;
    enter_res.granted = 1'b1;
    enter_res.last_result = 1'b1;
  end

  always_comb begin
    none_res = '0;
    none_res.send_kind = lgda_pkg::KIND_NONE;
    none_res.gate_direction = cur_dir;
    none_res.last_result = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      node_rank <= 4'd0;
      node_count <= 5'd2;
      own_dir <= 2'd1;
      gate_cap <= 5'd1;
      clock_value <= '0;
      flags <= '0;
      ack_total <= '0;
      cur_dir <= lgda_pkg::DIR_NONE;
      inside_self <= 1'b0;
      finished <= 1'b0;
      out_valid <= 1'b0;
      more <= 1'b0;
      first_v <= 1'b0;
      grant_v <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          lgda_pkg::REG_NODE_RANK:     node_rank <= cfg_data[3:0];
          lgda_pkg::REG_NODE_COUNT:    node_count <= cfg_data;
          lgda_pkg::REG_OWN_DIRECTION: own_dir <= cfg_data[1:0];
          lgda_pkg::REG_GATE_CAPACITY: gate_cap <= cfg_data;
          default: ;
        endcase
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            it <= in_data;
            first_v <= 1'b0;
            grant_v <= 1'b0;
            scan_idx <= '0;
            total <= '0;
            seen_a <= '0;
            seen_b <= '0;
            done_a <= 1'b0;
            done_b <= 1'b0;
            front_a <= 1'b0;
            front_b <= 1'b0;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          state <= S_LOAD;
          if (!finished) begin
            case (it.operation)
              lgda_pkg::OP_START: begin
                if (start_ok) begin
                  clock_value <= lgda_pkg::tick(clock_value);
                  first_v <= 1'b1;
                  first_kind <= lgda_pkg::KIND_REQUEST;
                  first_ts <= lgda_pkg::tick(clock_value);
                  first_dest <= 4'd0;
                end
              end
              lgda_pkg::OP_REQUEST: begin
                clock_value <= lgda_pkg::tick(msg_max);
                state <= S_TICK2;
              end
              lgda_pkg::OP_ACK: begin
                clock_value <= lgda_pkg::tick(msg_max);
                if (ack_total < lgda_pkg::ACK_MAX) begin
                  ack_total <= ack_total + 5'd1;
                end
                state <= S_SCAN;
              end
              lgda_pkg::OP_RELEASE: begin
                clock_value <= lgda_pkg::tick(msg_max);
                for (int i = 0; i < NODES; i++) begin
                  if (32'(it.msg_rank) == i) begin
                    flags[i] <= 1'b0;
                  end
                end
                state <= S_SCAN;
              end
              lgda_pkg::OP_ENTER: begin
                clock_value <= lgda_pkg::tick(msg_max);
                for (int i = 0; i < NODES; i++) begin
                  if (32'(it.msg_rank) == i) begin
                    flags[i] <= 1'b1;
                  end
                end
                state <= S_SCAN;
              end
              lgda_pkg::OP_LEAVE: begin
                if (inside_self) begin
                  inside_self <= 1'b0;
                  for (int i = 0; i < NODES; i++) begin
                    if (32'(node_rank) == i) begin
                      flags[i] <= 1'b0;
                    end
                  end
                  clock_value <= lgda_pkg::tick(clock_value);
                  first_v <= 1'b1;
                  first_kind <= lgda_pkg::KIND_RELEASE;
                  first_ts <= lgda_pkg::tick(clock_value);
                  first_dest <= 4'd0;
                  finished <= 1'b1;
                  state <= S_SCAN;
                end
              end
              default: ;
            endcase
          end
        end
        S_TICK2: begin
          // ack carries the clock after a second tick
          clock_value <= lgda_pkg::tick(clock_value);
          first_v <= 1'b1;
          first_kind <= lgda_pkg::KIND_ACK;
          first_ts <= lgda_pkg::tick(clock_value);
          first_dest <= it.msg_rank;
          state <= S_SCAN;
        end
        S_SCAN: begin
          if (flags[scan_idx] && (32'(scan_idx) < 32'(node_count))) begin
            total <= total + CNT_W'(1);
          end
          // candidate a: current direction, candidate b: direction of the head
          if (scan_occ && (scan_ent.dir == cur_dir) && !done_a) begin
            if (scan_ent.rank == node_rank) begin
              done_a <= 1'b1;
              front_a <= CMP_W'(seen_a) < CMP_W'(gate_cap);
            end else begin
              seen_a <= seen_a + CNT_W'(1);
            end
          end
          if (scan_occ && (scan_ent.dir == head_dir) && !done_b) begin
            if (scan_ent.rank == node_rank) begin
              done_b <= 1'b1;
              front_b <= CMP_W'(seen_b) < CMP_W'(gate_cap);
            end else begin
              seen_b <= seen_b + CNT_W'(1);
            end
          end
          if (scan_idx == IDX_W'(NODES - 1)) begin
            state <= S_DECIDE;
          end else begin
            scan_idx <= scan_idx + IDX_W'(1);
          end
        end
        S_DECIDE: begin
          cur_dir <= dir_new;
          if (grant) begin
            for (int i = 0; i < NODES; i++) begin
              if (32'(node_rank) == i) begin
                flags[i] <= 1'b1;
              end
            end
            inside_self <= 1'b1;
            clock_value <= lgda_pkg::tick(clock_value);
            grant_v <= 1'b1;
          end
          state <= S_LOAD;
        end
        S_LOAD: begin
          out_valid <= 1'b1;
          if (first_v) begin
            out_data.send_kind <= first_kind;
            out_data.send_timestamp <= first_ts;
            out_data.send_dest <= first_dest;
            out_data.gate_direction <= cur_dir;
            out_data.granted <= 1'b0;
            out_data.last_result <= !grant_v;
            more <= grant_v;
          end else if (grant_v) begin
            out_data <= enter_res;
            more <= 1'b0;
          end else begin
            out_data <= none_res;
            more <= 1'b0;
          end
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (!out_stall) begin
            if (more) begin
              out_data <= enter_res;
              more <= 1'b0;
            end else begin
              out_valid <= 1'b0;
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/core/lgda_cell.sv -----
// one cell of the sorted request queue: holds one entry, shifts to/from neighbors
// depends on lgda_pkg
module lgda_cell #(
  parameter int IDX = 0,
  parameter int CNT_W = 5
) (
  input  logic               clk,
  input  lgda_pkg::qcmd_t    cmd,
  input  logic [CNT_W-1:0]   count,
  input  lgda_pkg::entry_t   prev_ent,
  input  logic               prev_gt,
  input  lgda_pkg::entry_t   next_ent,
  input  logic               hit_in,
  output lgda_pkg::entry_t   ent,
  output logic               gt,
  output logic               hit_out
);

  logic occ;
  logic hit;
  logic at_tail;

  assign occ = CNT_W'(IDX) < count;
  assign at_tail = CNT_W'(IDX) == count;
  assign gt = occ && ((ent.ts > cmd.ent.ts) ||
                      ((ent.ts == cmd.ent.ts) && (ent.rank > cmd.ent.rank)));
  assign hit = occ && (ent.rank == cmd.key);
  assign hit_out = hit_in | hit;

  always_ff @(posedge clk) begin
    if (cmd.ins) begin
      if (prev_gt) begin
        ent <= prev_ent;
      end else if (gt || at_tail) begin
        ent <= cmd.ent;
      end
    end else if (cmd.rem && (hit_in || hit)) begin
      // close the gap left by the first matching entry
      ent <= next_ent;
    end
  end

endmodule

// ----- rtl/core/lgda_queue.sv -----
// request queue as a chain of cells sorted by timestamp then rank, plus fill count
// depends on lgda_pkg and lgda_cell
module lgda_queue #(
  parameter int NODES = lgda_pkg::NODES_DEF,
  parameter int CNT_W = $clog2(NODES + 1)
) (
  input  logic               clk,
  input  logic               rst,
  input  lgda_pkg::qcmd_t    cmd,
  output lgda_pkg::entry_t   ents [NODES],
  output logic [CNT_W-1:0]   count,
  output logic               any_hit
);

  logic             gts  [NODES];
  logic             hits [NODES+1];
  lgda_pkg::entry_t zero_ent;

  assign zero_ent = '0;
  assign hits[0] = 1'b0;
  assign any_hit = hits[NODES];

  for (genvar i = 0; i < NODES; i++) begin : g_cell
    lgda_pkg::entry_t prev_e;
    lgda_pkg::entry_t next_e;
    logic             prev_g;
    if (i == 0) begin : g_first
      assign prev_e = zero_ent;
      assign prev_g = 1'b0;
    end else begin : g_mid
      assign prev_e = ents[i-1];
      assign prev_g = gts[i-1];
    end
    if (i == NODES - 1) begin : g_last
      assign next_e = ents[i];
    end else begin : g_inner
      assign next_e = ents[i+1];
    end
    lgda_cell #(.IDX(i), .CNT_W(CNT_W)) u_cell (
      .clk      (clk),
      .cmd      (cmd),
      .count    (count),
      .prev_ent (prev_e),
      .prev_gt  (prev_g),
      .next_ent (next_e),
      .hit_in   (hits[i]),
      .ent      (ents[i]),
      .gt       (gts[i]),
      .hit_out  (hits[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.ins && (count < CNT_W'(NODES))) begin
      count <= count + CNT_W'(1);
    end else if (cmd.rem && any_hit) begin
      count <= count - CNT_W'(1);
    end
  end

endmodule

// ----- rtl/core/lgda_checker.sv -----
// port-level checks for the lamport direction gate arbiter, bound to the top level
// depends on lgda_pkg and the assertion macro header
`include "lamport_direction_gate_arbiter_top_macros.svh"

module lgda_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             in_stall,
  input logic                             out_valid,
  input logic                             out_stall,
  input lgda_pkg::res_t                   out_data
);

  `LGDA_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_data), "result word changed while stalled")
  `LGDA_ASSERT(a_grant_kind, out_valid && out_data.granted |-> out_data.send_kind == lgda_pkg::KIND_ENTER && out_data.last_result, "grant not on a final enter word")
  `LGDA_ASSERT(a_none_last, out_valid && out_data.send_kind == lgda_pkg::KIND_NONE |-> out_data.last_result, "empty result not final")
  `LGDA_ASSERT(a_one_at_a_time, !in_stall |-> !out_valid, "input taken while a result is pending")

endmodule

bind lamport_direction_gate_arbiter_top lgda_checker u_lgda_checker (.*);

// ----- tb/sv/lamport_direction_gate_arbiter_top_test.sv -----
// self-checking testbench for lamport_direction_gate_arbiter_top: directed words, then random
// phases under several register settings; each result word matched to a fixed or predicted word
// depends on lgda_pkg and the arbiter rtl
module lamport_direction_gate_arbiter_top_test;

  localparam int NODES = lgda_pkg::NODES_DEF;
  localparam int LIMIT = 1000000;
  localparam int PHASE_WORDS = 400;
  localparam int HOLD_CYCLES = 400;
  localparam logic [1:0] LEFT_WAY = 2'd1;
  localparam logic [1:0] RIGHT_WAY = 2'd2;
  localparam logic [2:0] OP_UNUSED_A = 3'd6;
  localparam logic [2:0] OP_UNUSED_B = 3'd7;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  lgda_pkg::item_t in_data;
  logic out_valid;
  logic out_stall;
  lgda_pkg::res_t out_data;
  logic cfg_wr_en;
  logic [lgda_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [lgda_pkg::CFG_DATA_W-1:0] cfg_data;

  lamport_direction_gate_arbiter_top dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // predicted node state
  logic [31:0] lclock;
  logic [31:0] q_ts [NODES];
  logic [3:0] q_rank [NODES];
  logic [1:0] q_dir [NODES];
  int q_cnt;
  bit in_flag [NODES];
  int acks;
  logic [1:0] gate_dir;
  bit self_in;
  bit done;
  logic [3:0] my_rank;
  logic [4:0] n_nodes;
  logic [1:0] my_dir;
  logic [4:0] capacity;

  lgda_pkg::res_t pending_words[$];
  int errors = 0;
  int cycles = 0;
  bit steady = 0;
  bit hold_req = 0;

  typedef struct {
    lgda_pkg::item_t word;
    bit typed;
    lgda_pkg::res_t want;
  } step_t;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic void bump();
    if (lclock != 32'hFFFF_FFFF) lclock++;
  endfunction

  function automatic void q_insert(logic [31:0] ts, logic [3:0] rank, logic [1:0] dir);
    int pos;
    pos = 0;
    if (q_cnt >= NODES) return;
    while (pos < q_cnt && !(q_ts[pos] > ts || (q_ts[pos] == ts && q_rank[pos] > rank))) pos++;
    for (int i = q_cnt; i > pos; i--) begin
      q_ts[i] = q_ts[i-1];
      q_rank[i] = q_rank[i-1];
      q_dir[i] = q_dir[i-1];
    end
    q_ts[pos] = ts;
    q_rank[pos] = rank;
    q_dir[pos] = dir;
    q_cnt++;
  endfunction

  function automatic bit q_holds(logic [3:0] rank);
    for (int i = 0; i < q_cnt; i++)
      if (q_rank[i] == rank) return 1;
    return 0;
  endfunction

  // absent rank leaves the queue as it is
  function automatic void q_drop(logic [3:0] rank);
    int i;
    i = 0;
    while (i < q_cnt && q_rank[i] != rank) i++;
    if (i >= q_cnt) return;
    for (; i + 1 < q_cnt; i++) begin
      q_ts[i] = q_ts[i+1];
      q_rank[i] = q_rank[i+1];
      q_dir[i] = q_dir[i+1];
    end
    q_cnt--;
  endfunction

  function automatic int inside_sum();
    int c;
    c = 0;
    for (int i = 0; i < n_nodes && i < NODES; i++) c += in_flag[i];
    return c;
  endfunction

  function automatic bit in_front(logic [3:0] rank);
    int seen;
    seen = 0;
    if (gate_dir == lgda_pkg::DIR_NONE) return 0;
    for (int i = 0; i < q_cnt; i++)
      if (q_dir[i] == gate_dir) begin
        if (q_rank[i] == rank) return seen < capacity;
        seen++;
      end
    return 0;
  endfunction

  function automatic void steer_gate();
    if (q_cnt == 0) gate_dir = lgda_pkg::DIR_NONE;
    else if (gate_dir == lgda_pkg::DIR_NONE) gate_dir = q_dir[0];
    else if (q_dir[0] != gate_dir && inside_sum() == 0) gate_dir = q_dir[0];
  endfunction

  function automatic bit may_grant();
    int need;
    need = (n_nodes != 0) ? n_nodes - 1 : 0;
    if (self_in || gate_dir == lgda_pkg::DIR_NONE || my_dir != gate_dir) return 0;
    if (!in_front(my_rank)) return 0;
    if (inside_sum() >= capacity) return 0;
    return acks >= need;
  endfunction

  function automatic lgda_pkg::res_t mk_word(logic [2:0] kind, logic [31:0] ts,
                                             logic [3:0] dest);
    lgda_pkg::res_t r;
    r = '0;
    r.send_kind = kind;
    r.send_timestamp = ts;
    r.send_dest = dest;
    r.granted = (kind == lgda_pkg::KIND_ENTER);
    return r;
  endfunction

  // advances the node state by one word; queues the result words when keep is set
  function automatic void node_step(lgda_pkg::item_t it, bit keep);
    lgda_pkg::res_t w [2];
    int n;
    n = 0;
    if (!done) begin
      if (it.operation == lgda_pkg::OP_START) begin
        if (!self_in && !q_holds(my_rank)) begin
          bump();
          q_insert(lclock, my_rank, my_dir);
          w[n++] = mk_word(lgda_pkg::KIND_REQUEST, lclock, 4'd0);
        end
      end else if (it.operation >= lgda_pkg::OP_REQUEST &&
                   it.operation <= lgda_pkg::OP_ENTER) begin
        if (it.msg_timestamp > lclock) lclock = it.msg_timestamp;
        bump();
        case (it.operation)
          lgda_pkg::OP_REQUEST: begin
            q_insert(it.msg_timestamp, it.msg_rank, it.msg_direction);
            steer_gate();
            bump();
            w[n++] = mk_word(lgda_pkg::KIND_ACK, lclock, it.msg_rank);
          end
          lgda_pkg::OP_ACK: begin
            if (acks < lgda_pkg::ACK_MAX) acks++;
            steer_gate();
          end
          lgda_pkg::OP_RELEASE: begin
            in_flag[it.msg_rank] = 0;
            q_drop(it.msg_rank);
            steer_gate();
          end
          default: in_flag[it.msg_rank] = 1;
        endcase
        if (may_grant()) begin
          in_flag[my_rank] = 1;
          self_in = 1;
          bump();
          w[n++] = mk_word(lgda_pkg::KIND_ENTER, lclock, 4'd0);
        end
      end else if (it.operation == lgda_pkg::OP_LEAVE && self_in) begin
        self_in = 0;
        in_flag[my_rank] = 0;
        q_drop(my_rank);
        bump();
        w[n++] = mk_word(lgda_pkg::KIND_RELEASE, lclock, 4'd0);
        steer_gate();
        done = 1;
      end
    end
    if (n == 0) w[n++] = mk_word(lgda_pkg::KIND_NONE, 32'd0, 4'd0);
    for (int k = 0; k < n; k++) begin
      w[k].gate_direction = gate_dir;
      w[k].last_result = (k == n - 1);
      if (keep) pending_words.push_back(w[k]);
    end
  endfunction

  function automatic lgda_pkg::item_t mk_item(logic [2:0] op, logic [31:0] ts,
                                              logic [3:0] rank, logic [1:0] dir);
    lgda_pkg::item_t it;
    it.operation = op;
    it.msg_timestamp = ts;
    it.msg_rank = rank;
    it.msg_direction = dir;
    return it;
  endfunction

  function automatic lgda_pkg::item_t random_item();
    lgda_pkg::item_t it;
    int pick;
    pick = $urandom_range(99);
    it.msg_rank = 4'($urandom_range(15));
    it.msg_direction = ($urandom_range(9) == 0) ? (($urandom_range(1) == 0) ? 2'd0 : 2'd3)
                     : (($urandom_range(1) == 0) ? LEFT_WAY : RIGHT_WAY);
    if ($urandom_range(99) < 3) it.msg_timestamp = $urandom;
    else if (lclock < 3) it.msg_timestamp = $urandom_range(3);
    else it.msg_timestamp = lclock - 2 + $urandom_range(4);
    if (pick < 6) it.operation = lgda_pkg::OP_START;
    else if (pick < 36) it.operation = lgda_pkg::OP_REQUEST;
    else if (pick < 54) it.operation = lgda_pkg::OP_ACK;
    else if (pick < 76) begin
      it.operation = lgda_pkg::OP_RELEASE;
      if (q_cnt > 0 && $urandom_range(1) == 0) it.msg_rank = q_rank[$urandom_range(q_cnt - 1)];
    end else if (pick < 88) it.operation = lgda_pkg::OP_ENTER;
    // a real leave would end the node, so it is kept for the closing words
    else if (pick < 93 && !self_in) it.operation = lgda_pkg::OP_LEAVE;
    else it.operation = ($urandom_range(1) == 0) ? OP_UNUSED_A : OP_UNUSED_B;
    return it;
  endfunction

  task automatic send_word(lgda_pkg::item_t it, bit typed, lgda_pkg::res_t want);
    @(negedge clk);
    if (!steady)
      while ($urandom_range(99) < 25) begin
        in_valid <= 1'b0;
        @(negedge clk);
      end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    node_step(it, !typed);
    if (typed) pending_words.push_back(want);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (NODES + 8) @(negedge clk);
  endtask

  task automatic set_regs(logic [4:0] rank, logic [4:0] count, logic [4:0] dir, logic [4:0] cap);
    logic [4:0] vals [4];
    vals = '{rank, count, dir, cap};
    drain();
    for (int i = 0; i < 4; i++) begin
      cfg_wr_en <= 1'b1;
      cfg_index <= lgda_pkg::CFG_IDX_W'(i);
      cfg_data <= vals[i];
      case (i)
        lgda_pkg::REG_NODE_RANK: my_rank = rank[3:0];
        lgda_pkg::REG_NODE_COUNT: n_nodes = count;
        lgda_pkg::REG_OWN_DIRECTION: my_dir = dir[1:0];
        default: capacity = cap;
      endcase
      @(negedge clk);
    end
    cfg_wr_en <= 1'b0;
  endtask

  // result side: random stall, one long hold on request
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 0;
        out_stall <= 1'b0;
      end else begin
        out_stall <= steady ? 1'b0 : ($urandom_range(99) < 25);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_words.size() == 0) begin
        $display("%0t: unexpected word %h", $time, out_data);
        errors++;
      end else begin
        lgda_pkg::res_t e;
        e = pending_words.pop_front();
        if (e.send_kind != out_data.send_kind)
          $display("%0t: send_kind exp %0d got %0d", $time, e.send_kind, out_data.send_kind);
        if (e.send_timestamp != out_data.send_timestamp)
          $display("%0t: send_timestamp exp %h got %h", $time, e.send_timestamp,
                   out_data.send_timestamp);
        if (e.send_dest != out_data.send_dest)
          $display("%0t: send_dest exp %0d got %0d", $time, e.send_dest, out_data.send_dest);
        if (e.gate_direction != out_data.gate_direction)
          $display("%0t: gate_direction exp %0d got %0d", $time, e.gate_direction,
                   out_data.gate_direction);
        if (e.granted != out_data.granted)
          $display("%0t: granted exp %0d got %0d", $time, e.granted, out_data.granted);
        if (e.last_result != out_data.last_result)
          $display("%0t: last_result exp %0d got %0d", $time, e.last_result,
                   out_data.last_result);
        if (e != out_data) errors++;
      end
    end
  end

  initial begin
    step_t plan [$];
    logic [4:0] regs [5][4];
    lgda_pkg::res_t none_w;
    clk = 1'b0;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_wr_en = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    lclock = '0;
    q_cnt = 0;
    acks = 0;
    gate_dir = lgda_pkg::DIR_NONE;
    self_in = 0;
    done = 0;
    foreach (in_flag[i]) in_flag[i] = 0;
    my_rank = 4'd0;
    n_nodes = 5'd2;
    my_dir = LEFT_WAY;
    capacity = 5'd1;
    none_w = mk_word(lgda_pkg::KIND_NONE, 32'd0, 4'd0);
    none_w.last_result = 1'b1;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: ignored codes and leave, start, then queue ordering, removal, enter and ack cases
    plan.push_back('{mk_item(OP_UNUSED_B, 32'hFFFF_FFFF, 4'd15, 2'd3), 1, none_w});
    plan.push_back('{mk_item(OP_UNUSED_A, 32'd0, 4'd0, 2'd0), 1, none_w});
    plan.push_back('{mk_item(lgda_pkg::OP_LEAVE, 32'd0, 4'd0, LEFT_WAY), 1, none_w});
    plan.push_back('{mk_item(lgda_pkg::OP_START, 32'd0, 4'd0, LEFT_WAY), 1,
                     '{lgda_pkg::KIND_REQUEST, 32'd1, 4'd0, lgda_pkg::DIR_NONE, 1'b0, 1'b1}});
    plan.push_back('{mk_item(lgda_pkg::OP_START, 32'd0, 4'd0, LEFT_WAY), 1, none_w});
    plan.push_back('{mk_item(lgda_pkg::OP_REQUEST, 32'd0, 4'd15, LEFT_WAY), 0, none_w});
    plan.push_back('{mk_item(lgda_pkg::OP_REQUEST, 32'd5, 4'd3, RIGHT_WAY), 0, none_w});
    plan.push_back('{mk_item(lgda_pkg::OP_REQUEST, 32'd5, 4'd3, RIGHT_WAY), 0, none_w});
    plan.push_back('{mk_item(lgda_pkg::OP_REQUEST, 32'd7, 4'd9, 2'd0), 0, none_w});
    plan.push_back('{mk_item(lgda_pkg::OP_REQUEST, 32'd7, 4'd10, 2'd3), 0, none_w});
    plan.push_back('{mk_item(lgda_pkg::OP_RELEASE, 32'd2, 4'd12, LEFT_WAY), 0, none_w});
    plan.push_back('{mk_item(lgda_pkg::OP_RELEASE, 32'd9, 4'd3, LEFT_WAY), 0, none_w});
    plan.push_back('{mk_item(lgda_pkg::OP_ENTER, 32'd1, 4'd15, LEFT_WAY), 0, none_w});
    plan.push_back('{mk_item(lgda_pkg::OP_ENTER, 32'd30, 4'd7, RIGHT_WAY), 0, none_w});
    plan.push_back('{mk_item(lgda_pkg::OP_ACK, 32'd0, 4'd15, LEFT_WAY), 0, none_w});
    plan.push_back('{mk_item(lgda_pkg::OP_RELEASE, 32'd0, 4'd3, RIGHT_WAY), 0, none_w});
    foreach (plan[i]) send_word(plan[i].word, plan[i].typed, plan[i].want);

    // own direction 0 keeps the early phases from granting
    regs = '{'{5, 16, 0, 16}, '{15, 2, 0, 0}, '{0, 0, 3, 1}, '{9, 31, 2, 5}, '{3, 4, 1, 2}};
    for (int p = 0; p < 5; p++) begin
      set_regs(regs[p][0], regs[p][1], regs[p][2], regs[p][3]);
      for (int k = 0; k < PHASE_WORDS; k++) begin
        steady = (p == 3 && k < 200);
        if (p == 1 && k == 100) hold_req = 1;
        if (p == 2 && k == 200) drain();
        send_word(random_item(), 0, none_w);
      end
    end
    steady = 0;

    // clock saturation, then the leave and words that must be ignored after it
    send_word(mk_item(lgda_pkg::OP_ACK, 32'hFFFF_FFFF, 4'd1, LEFT_WAY), 0, none_w);
    send_word(mk_item(lgda_pkg::OP_REQUEST, 32'hFFFF_FFFF, 4'd2, RIGHT_WAY), 0, none_w);
    send_word(mk_item(lgda_pkg::OP_LEAVE, 32'd0, 4'd0, LEFT_WAY), 0, none_w);
    send_word(mk_item(lgda_pkg::OP_START, 32'd0, 4'd0, LEFT_WAY), 0, none_w);
    send_word(mk_item(lgda_pkg::OP_REQUEST, 32'd4, 4'd6, LEFT_WAY), 0, none_w);
    send_word(mk_item(lgda_pkg::OP_LEAVE, 32'd0, 4'd0, LEFT_WAY), 0, none_w);

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (4 * NODES) @(posedge clk);
    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
